[src/mzf_pkg.sv]
// Shared types, constants and codes for the multi-zone fade ramp.
package mzf_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int ZONES_DEF  = 6;
  localparam int ZONE_W     = 3;
  localparam int TIME_W     = 16;
  localparam int DIV_W      = 18;
  localparam int DCNT_W     = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0] TICK_DIV_RST = 16'd5000;
  localparam logic              DISP_EN_RST  = 1'b1;

  localparam logic signed [1:0] STEP_NONE = 2'sb00;
  localparam logic signed [1:0] STEP_UP   = 2'sb01;
  localparam logic signed [1:0] STEP_DOWN = 2'sb11;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TICK_DIV = 1'b0,
    REG_DISP_EN  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV1,
    ST_DIV2,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t                 func;
    logic [ZONE_W-1:0]     zone;
    logic [LEVEL_BITS-1:0] target;
    logic [TIME_W-1:0]     fade_time;
    logic [LEVEL_BITS-1:0] threshold;
    logic                  bypass;
  } item_t;

  typedef struct packed {
    logic                  need_div;
    logic [LEVEL_BITS-1:0] cnt;
    logic [LEVEL_BITS-1:0] level;
    logic signed [1:0]     step;
    logic                  show;
    logic                  active;
    logic                  all_done;
  } eval_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

endpackage

[src/mzf_div.sv]
// Bit-serial restoring divider computing round-half-up num/den.
module mzf_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mzf_pkg::div_req_t              req,
  output logic                           done,
  output logic [mzf_pkg::TIME_W-1:0]     quot
);

  localparam int DW = mzf_pkg::DIV_W;
  localparam int CW = mzf_pkg::DCNT_W;

  logic [DW-1:0] n_r, n_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW-2:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] rem_sh;
  logic [DW-1:0] rem_df;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, n_r[DW-1]};
    ge       = rem_sh >= d_r;
    rem_df   = rem_sh - d_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // dividend 2*num + den, divisor 2*den
      n_nxt    = {1'b0, req.num, 1'b0} + {2'b00, req.den};
      d_nxt    = {1'b0, req.den, 1'b0};
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt   = {n_r[DW-2:0], ge};
      rem_nxt = ge ? rem_df[DW-2:0] : rem_sh[DW-2:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = n_r[mzf_pkg::TIME_W-1:0];

endmodule

[src/mzf_zone_bank.sv]
// Per-zone fade state, start evaluation and tick stepping.
module mzf_zone_bank #(
  parameter int ZONES = mzf_pkg::ZONES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mzf_pkg::item_t              item,
  input  logic                        disp_en,
  input  logic                        commit,
  input  logic [mzf_pkg::TIME_W-1:0]  tps_in,
  output mzf_pkg::eval_t              ev
);

  localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
  localparam int LB = mzf_pkg::LEVEL_BITS;
  localparam int TW = mzf_pkg::TIME_W;
  localparam logic [LB-1:0] LVL_MAX = '1;

  logic [LB-1:0]    level_r [ZONES];
  logic             up_r    [ZONES];
  logic [LB-1:0]    total_r [ZONES];
  logic [LB-1:0]    done_r  [ZONES];
  logic [TW-1:0]    tps_r   [ZONES];
  logic [TW-1:0]    tc_r    [ZONES];
  logic [ZONES-1:0] act_r;

  logic              in_rng;
  logic [ZW-1:0]     sel;
  logic [LB-1:0]     cur;
  logic              is_start;
  logic              up;
  logic [LB-1:0]     diff;
  logic              rule;
  logic signed [LB:0] cnt9;
  logic              cnt_pos;
  logic              chg;
  logic              tick_run;
  logic [TW-1:0]     tc_inc;
  logic              hit;
  logic [LB-1:0]     lvl_nxt;
  logic signed [1:0] step;
  logic              act_new;
  logic [TW-1:0]     tc_nxt;
  logic [LB-1:0]     dn_nxt;
  logic              show;
  logic [ZONES-1:0]  act_vec;

  always_comb begin
    in_rng   = 32'(item.zone) < ZONES;
    sel      = in_rng ? ZW'(item.zone) : '0;
    cur      = level_r[sel];
    is_start = item.func == mzf_pkg::FUNC_START;
    up       = item.target > cur;
    diff     = up ? item.target - cur : cur - item.target;
    rule     = item.bypass && (up ? (cur <= item.threshold) : (item.target <= item.threshold));
    cnt9     = $signed({1'b0, diff}) - $signed({1'b0, rule ? item.threshold : {LB{1'b0}}});
    cnt_pos  = !cnt9[LB] && (cnt9 != '0);
    chg      = is_start && (item.target != cur);
    tick_run = !is_start && act_r[sel];
    tc_inc   = tc_r[sel] + 1'b1;
    hit      = tc_inc >= tps_r[sel];

    lvl_nxt = cur;
    step    = mzf_pkg::STEP_NONE;
    act_new = act_r[sel];
    tc_nxt  = tc_inc;
    dn_nxt  = done_r[sel];
    show    = 1'b0;

    if (chg) begin
      act_new = cnt_pos;
      show    = up && rule && (cur == '0) && disp_en;
    end
    if (tick_run) begin
      if (hit) begin
        tc_nxt = '0;
        dn_nxt = done_r[sel] + 1'b1;
        if (up_r[sel]) begin
          if (cur != LVL_MAX) begin
            lvl_nxt = cur + 1'b1;
            step    = mzf_pkg::STEP_UP;
          end
        end else if (cur != '0) begin
          lvl_nxt = cur - 1'b1;
          step    = mzf_pkg::STEP_DOWN;
        end
      end
      act_new = !(dn_nxt >= total_r[sel]);
    end

    act_vec = act_r;
    if (in_rng) begin
      act_vec[sel] = act_new;
    end

    ev.need_div = in_rng && chg && cnt_pos;
    ev.cnt      = cnt9[LB-1:0];
    ev.level    = in_rng ? lvl_nxt : '0;
    ev.step     = in_rng ? step : mzf_pkg::STEP_NONE;
    ev.show     = in_rng && show;
    ev.active   = in_rng && act_new;
    ev.all_done = ~|act_vec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      for (int z = 0; z < ZONES; z++) begin
        level_r[z] <= '0;
      end
    end else if (commit && in_rng) begin
      act_r[sel]   <= act_new;
      level_r[sel] <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && in_rng) begin
      if (chg && cnt_pos) begin
        up_r[sel]    <= up;
        total_r[sel] <= cnt9[LB-1:0];
        tps_r[sel]   <= tps_in;
        tc_r[sel]    <= '0;
        done_r[sel]  <= '0;
      end else if (tick_run) begin
        tc_r[sel]   <= tc_nxt;
        done_r[sel] <= dn_nxt;
      end
    end
  end

endmodule

[src/multi_zone_fade_ramp_core.sv]
// Multi-zone fade ramp top level: stream ports, sequencer, config and output word.
// Path: a start that begins a fade goes from accept through EVAL, DIV1 and DIV2 (two
// passes of the bit-serial divider) and DONE to out_tvalid; all other words skip DIV1/DIV2.
// Throughput: one word at a time; next word is accepted the cycle after the result
// is loaded, even while that result waits on out_tready.
// Reset (rst_n low, sync): zones idle at level 0, divisor 5000, display on, no output.
module multi_zone_fade_ramp_core #(
  parameter int ZONES = mzf_pkg::ZONES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // zone, target_level, fade_time, threshold, bypass_below_threshold
  input  logic [mzf_pkg::IN_DATA_W-1:0]    in_tdata,
  // func
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_zone, level, step, show_threshold, fade_active, all_done
  output logic [mzf_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_we,
  input  logic [mzf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mzf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int TW = mzf_pkg::TIME_W;

  mzf_pkg::state_t   state_r, state_nxt;
  mzf_pkg::item_t    item_r, item_in;
  mzf_pkg::eval_t    ev;
  mzf_pkg::div_req_t div_req;
  logic [TW-1:0]     tdiv_r;
  logic              disp_r;
  logic [TW-1:0]     den2;
  logic              div_done;
  logic [TW-1:0]     div_q;
  logic              in_acc;
  logic              out_free;
  logic              commit;
  logic              out_valid_r;
  logic [mzf_pkg::OUT_DATA_W-1:0] out_data_r;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign den2     = (tdiv_r == '0) ? TW'(1) : tdiv_r;

  always_comb begin
    item_in.func      = mzf_pkg::func_t'(in_tuser);
    item_in.zone      = in_tdata[2:0];
    item_in.target    = in_tdata[10:3];
    item_in.fade_time = in_tdata[26:11];
    item_in.threshold = in_tdata[34:27];
    item_in.bypass    = in_tdata[35];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdiv_r <= mzf_pkg::TICK_DIV_RST;
      disp_r <= mzf_pkg::DISP_EN_RST;
    end else if (cfg_we) begin
      unique case (mzf_pkg::cfg_reg_t'(cfg_addr))
        mzf_pkg::REG_TICK_DIV: tdiv_r <= cfg_wdata;
        mzf_pkg::REG_DISP_EN:  disp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mzf_pkg::ST_IDLE: if (in_acc) state_nxt = mzf_pkg::ST_EVAL;
      mzf_pkg::ST_EVAL: state_nxt = ev.need_div ? mzf_pkg::ST_DIV1 : mzf_pkg::ST_DONE;
      mzf_pkg::ST_DIV1: if (div_done) state_nxt = mzf_pkg::ST_DIV2;
      mzf_pkg::ST_DIV2: if (div_done) state_nxt = mzf_pkg::ST_DONE;
      mzf_pkg::ST_DONE: if (out_free) state_nxt = mzf_pkg::ST_IDLE;
      default: state_nxt = mzf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    commit        = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = item_r.fade_time;
    div_req.den   = TW'(ev.cnt);
    unique case (state_r)
      mzf_pkg::ST_IDLE: in_tready = 1'b1;
      mzf_pkg::ST_EVAL: div_req.start = ev.need_div;
      mzf_pkg::ST_DIV1: begin
        div_req.start = div_done;
        div_req.num   = div_q;
        div_req.den   = den2;
      end
      mzf_pkg::ST_DIV2: ;
      mzf_pkg::ST_DONE: commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mzf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= {ev.all_done, ev.active, ev.show, ev.step, ev.level, item_r.zone};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  mzf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  mzf_zone_bank #(
    .ZONES (ZONES)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item_r),
    .disp_en (disp_r),
    .commit  (commit),
    .tps_in  (div_q),
    .ev      (ev)
  );

endmodule
